// ===== hw/rtl/bfdp_pkg.sv =====
// Shared types and constants for the bf16 row dot product block.
// Used by every module under hw/rtl except bfdp_ram; depends on nothing.
package bfdp_pkg;

  localparam int MAX_LENGTH     = 4096;
  localparam int ADDR_W         = $clog2(MAX_LENGTH);
  localparam int LEN_W          = 13;
  localparam int BLOCK_ELEMENTS = 32;
  localparam int BLOCK_SHIFT    = $clog2(BLOCK_ELEMENTS);
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = QPTR_W + 1;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(BLOCK_ELEMENTS);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_LENGTH);
  localparam logic [31:0]      CANON_NAN = 32'h7FC0_0000;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_ROW  = 1'b1
  } cmd_t;

  // Classification of one row element, worked out by the front end.
  typedef struct packed {
    logic [15:0] elem;
    logic        active;
    logic        block;
    logic        last;
    logic        err;
    logic        tail_nonempty;
  } row_tag_t;

  typedef struct packed {
    row_tag_t    tag;
    logic [15:0] query;
  } entry_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] a;
    logic [31:0] b;
    logic        ftz;
  } add_req_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] sum;
  } add_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_WAIT,
    ST_END,
    ST_FINAL,
    ST_FWAIT,
    ST_OUT
  } back_state_t;

endpackage

// ===== hw/rtl/bfdp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
module bfdp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bfdp_queue.sv =====
// Short queue of classified row elements between the front and back ends.
// Depends on bfdp_pkg.
module bfdp_queue
  import bfdp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  entry_t        push_data,
  input  logic          pop,
  output entry_t        head,
  output queue_status_t status
);

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign head         = slots[rd_ptr];
  assign status.empty = (count == '0);
  assign status.count = count;

endmodule

// ===== hw/rtl/bfdp_front.sv =====
// Front end: takes input words, fills the query store, tags row elements
// and reads the matching query element. Depends on bfdp_pkg and bfdp_ram.
module bfdp_front
  import bfdp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             cmd,
  input  logic [15:0]      element,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data,
  input  queue_status_t    q_status,
  output logic             q_push,
  output entry_t           q_data
);

  logic [LEN_W-1:0]  vector_length;
  logic [LEN_W-1:0]  load_position;
  logic [LEN_W-1:0]  load_position_next;
  logic [LEN_W-1:0]  row_position;
  logic [LEN_W-1:0]  row_position_next;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  block_limit;
  logic              accept;
  logic              is_row;
  row_tag_t          tag;
  row_tag_t          s1_tag;
  logic              s1_valid;
  logic [15:0]       query_rdata;

  assign len         = (vector_length > LEN_MAX) ? LEN_MAX : vector_length;
  assign block_limit = {len[LEN_W-1:BLOCK_SHIFT], BLOCK_SHIFT'(0)};

  // The word in the read stage always has a slot reserved in the queue.
  assign full   = (QCNT_W'(q_status.count) + QCNT_W'(s1_valid)) >= QCNT_W'(QDEPTH);
  assign accept = push && !full;
  assign is_row = (cmd == CMD_ROW);

  always_comb begin
    tag.elem          = element;
    tag.active        = (row_position < len);
    tag.block         = (row_position < block_limit);
    tag.last          = ((row_position + 1'b1) >= len);
    tag.err           = (len < LEN_W'(BLOCK_ELEMENTS));
    tag.tail_nonempty = (block_limit != len);
    load_position_next = ((load_position + 1'b1) >= len) ? '0 : load_position + 1'b1;
    row_position_next  = tag.last ? '0 : row_position + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= LEN_RESET;
      load_position <= '0;
      row_position  <= '0;
      s1_valid      <= 1'b0;
    end else begin
      s1_valid <= accept && is_row;
      if (cfg_we) begin
        vector_length <= cfg_data;
        load_position <= '0;
        row_position  <= '0;
      end else if (accept) begin
        if (is_row) begin
          row_position <= row_position_next;
        end else begin
          load_position <= load_position_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_row) begin
      s1_tag <= tag;
    end
  end

  bfdp_ram #(
    .WIDTH(16),
    .DEPTH(MAX_LENGTH)
  ) u_query_store (
    .clk  (clk),
    .we   (accept && !is_row),
    .waddr(load_position[ADDR_W-1:0]),
    .wdata(element),
    .raddr(row_position[ADDR_W-1:0]),
    .rdata(query_rdata)
  );

  assign q_push       = s1_valid;
  assign q_data.tag   = s1_tag;
  assign q_data.query = query_rdata;

endmodule

// ===== hw/rtl/bfdp_fp_add.sv =====
// Four-stage fp32 adder: align, add, leading-zero count, normalize and round.
// Round to nearest even, optional flush of a subnormal sum. Depends on bfdp_pkg.
module bfdp_fp_add
  import bfdp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  add_req_t req,
  output add_rsp_t rsp
);

  // Stage 1: unpack, order by magnitude, align the smaller operand.
  logic        s1_valid, s1_special, s1_sign, s1_sub, s1_zsign, s1_ftz;
  logic [31:0] s1_spec_val;
  logic [7:0]  s1_exp;
  logic [26:0] s1_big, s1_small;

  logic        a_nan, b_nan, a_inf, b_inf, a_big;
  logic [31:0] big_op, small_op;
  logic [7:0]  e_big, e_small, shift_dist;
  logic [26:0] m_big, m_small, m_shift;
  logic        sticky;

  always_comb begin
    a_nan      = (req.a[30:23] == 8'hFF) && (req.a[22:0] != '0);
    b_nan      = (req.b[30:23] == 8'hFF) && (req.b[22:0] != '0);
    a_inf      = (req.a[30:23] == 8'hFF) && (req.a[22:0] == '0);
    b_inf      = (req.b[30:23] == 8'hFF) && (req.b[22:0] == '0);
    a_big      = (req.a[30:0] >= req.b[30:0]);
    big_op     = a_big ? req.a : req.b;
    small_op   = a_big ? req.b : req.a;
    e_big      = (big_op[30:23] != '0) ? big_op[30:23] : 8'd1;
    e_small    = (small_op[30:23] != '0) ? small_op[30:23] : 8'd1;
    shift_dist = e_big - e_small;
    m_big      = {(big_op[30:23] != '0), big_op[22:0], 3'b000};
    m_small    = {(small_op[30:23] != '0), small_op[22:0], 3'b000};
    m_shift    = m_small >> shift_dist;
    sticky     = ((m_shift << shift_dist) != m_small);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_special  <= a_nan || b_nan || a_inf || b_inf;
    if (a_nan || b_nan || (a_inf && b_inf && (req.a[31] != req.b[31]))) begin
      s1_spec_val <= CANON_NAN;
    end else if (a_inf) begin
      s1_spec_val <= req.a;
    end else begin
      s1_spec_val <= req.b;
    end
    s1_sign  <= big_op[31];
    s1_sub   <= big_op[31] ^ small_op[31];
    s1_zsign <= req.a[31] & req.b[31];
    s1_ftz   <= req.ftz;
    s1_exp   <= e_big;
    s1_big   <= m_big;
    s1_small <= {m_shift[26:1], m_shift[0] | sticky};
  end

  // Stage 2: magnitude add or subtract.
  logic        s2_valid, s2_special, s2_sign, s2_zsign, s2_ftz;
  logic [31:0] s2_spec_val;
  logic [7:0]  s2_exp;
  logic [27:0] s2_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_special  <= s1_special;
    s2_spec_val <= s1_spec_val;
    s2_sign     <= s1_sign;
    s2_zsign    <= s1_zsign;
    s2_ftz      <= s1_ftz;
    s2_exp      <= s1_exp;
    s2_sum      <= s1_sub ? ({1'b0, s1_big} - {1'b0, s1_small})
                          : ({1'b0, s1_big} + {1'b0, s1_small});
  end

  // Stage 3: leading-zero count, limited so the exponent stays at one or more.
  logic        s3_valid, s3_special, s3_sign, s3_zsign, s3_ftz, s3_zero;
  logic [31:0] s3_spec_val;
  logic [8:0]  s3_exp;
  logic [26:0] s3_mant;
  logic [4:0]  s3_shamt;

  logic [4:0]  lz;
  logic [7:0]  lz_limit;

  always_comb begin
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (s2_sum[i]) begin
        lz = 5'(26 - i);
      end
    end
    lz_limit = s2_exp - 8'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_special  <= s2_special;
    s3_spec_val <= s2_spec_val;
    s3_sign     <= s2_sign;
    s3_zsign    <= s2_zsign;
    s3_ftz      <= s2_ftz;
    s3_zero     <= (s2_sum == '0);
    if (s2_sum[27]) begin
      s3_mant  <= {s2_sum[27:2], |s2_sum[1:0]};
      s3_exp   <= {1'b0, s2_exp} + 9'd1;
      s3_shamt <= '0;
    end else begin
      s3_mant  <= s2_sum[26:0];
      s3_exp   <= {1'b0, s2_exp};
      s3_shamt <= ({3'b000, lz} < lz_limit) ? lz : lz_limit[4:0];
    end
  end

  // Stage 4: shift, round to nearest even, pack.
  logic [26:0] m_norm;
  logic [9:0]  e_norm, e_round;
  logic        round_up;
  logic [24:0] sig_wide;
  logic [23:0] sig;
  logic [31:0] packed_val;

  always_comb begin
    m_norm   = s3_mant << s3_shamt;
    e_norm   = {1'b0, s3_exp} - {5'b0, s3_shamt};
    round_up = m_norm[2] & (m_norm[1] | m_norm[0] | m_norm[3]);
    sig_wide = {1'b0, m_norm[26:3]} + 25'(round_up);
    if (sig_wide[24]) begin
      sig     = sig_wide[24:1];
      e_round = e_norm + 10'd1;
    end else begin
      sig     = sig_wide[23:0];
      e_round = e_norm;
    end
    if (s3_special) begin
      packed_val = s3_spec_val;
    end else if (s3_zero) begin
      packed_val = {s3_zsign, 31'b0};
    end else if (!sig[23]) begin
      packed_val = {s3_sign, 8'd0, sig[22:0]};
    end else if (e_round >= 10'd255) begin
      packed_val = {s3_sign, 8'hFF, 23'b0};
    end else begin
      packed_val = {s3_sign, e_round[7:0], sig[22:0]};
    end
    if (s3_ftz && (packed_val[30:23] == '0)) begin
      packed_val = {packed_val[31], 31'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else begin
      rsp.valid <= s3_valid;
    end
    rsp.sum <= packed_val;
  end

endmodule

// ===== hw/rtl/bfdp_back.sv =====
// Back end: multiplies each queued element pair, accumulates block and tail
// sums through the shared adder, and queues finished results.
// Depends on bfdp_pkg and bfdp_fp_add.
module bfdp_back
  import bfdp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_clear,
  input  entry_t        q_head,
  input  queue_status_t q_status,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [31:0]   dot_product,
  output logic          error
);

  // Exact bf16 product as fp32; rounding only happens in the subnormal range.
  function automatic logic [31:0] bf16_mul(input logic [15:0] a, input logic [15:0] b,
                                           input logic daz);
    logic [7:0]         ea, eb;
    logic [6:0]         fa, fb;
    logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sign;
    logic [7:0]         ma, mb, xa, xb;
    logic [15:0]        p;
    logic [4:0]         k;
    logic [8:0]         xsum;
    logic signed [10:0] ebias, t, negt;
    logic [4:0]         s;
    logic [33:0]        wide;
    logic [15:0]        ip;
    logic [23:0]        frac;
    logic [31:0]        res;
    ea = a[14:7];
    eb = b[14:7];
    fa = (daz && (ea == '0)) ? 7'd0 : a[6:0];
    fb = (daz && (eb == '0)) ? 7'd0 : b[6:0];
    sign   = a[15] ^ b[15];
    nan_a  = (ea == 8'hFF) && (fa != '0);
    nan_b  = (eb == 8'hFF) && (fb != '0);
    inf_a  = (ea == 8'hFF) && (fa == '0);
    inf_b  = (eb == 8'hFF) && (fb == '0);
    zero_a = (ea == '0) && (fa == '0);
    zero_b = (eb == '0) && (fb == '0);
    ma = {(ea != '0), fa};
    mb = {(eb != '0), fb};
    xa = (ea != '0) ? ea : 8'd1;
    xb = (eb != '0) ? eb : 8'd1;
    p  = ma * mb;
    k  = '0;
    for (int i = 0; i < 16; i++) begin
      if (p[i]) begin
        k = 5'(i);
      end
    end
    xsum  = {1'b0, xa} + {1'b0, xb};
    ebias = $signed({6'b0, k}) + $signed({2'b0, xsum}) - 11'sd141;
    t     = $signed({2'b0, xsum}) - 11'sd119;
    negt  = -t;
    s     = (negt > 11'sd18) ? 5'd18 : negt[4:0];
    wide  = {p, 18'b0} >> s;
    ip    = wide[33:18];
    if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
      res = CANON_NAN;
    end else if (inf_a || inf_b) begin
      res = {sign, 8'hFF, 23'b0};
    end else if (zero_a || zero_b) begin
      res = {sign, 31'b0};
    end else if (ebias >= 11'sd255) begin
      res = {sign, 8'hFF, 23'b0};
    end else if (ebias >= 11'sd1) begin
      frac = 24'(p) << (5'd23 - k);
      res  = {sign, ebias[7:0], frac[22:0]};
    end else begin
      if (t >= 11'sd0) begin
        frac = 24'(p) << t[4:0];
      end else begin
        frac = 24'(ip) + 24'(wide[17] & ((|wide[16:0]) | ip[0]));
      end
      res = {sign, 7'b0, frac};
    end
    return res;
  endfunction

  function automatic logic [31:0] canon(input logic [31:0] v);
    return ((v[30:23] == 8'hFF) && (v[22:0] != '0)) ? CANON_NAN : v;
  endfunction

  back_state_t state, state_next;
  entry_t      cur;
  logic [31:0] prod;
  logic [31:0] block_sum;
  logic [31:0] tail_sum;
  logic [31:0] res_val;
  logic        res_err;
  add_req_t    add_req;
  add_rsp_t    add_rsp;
  logic        out_push;
  logic        out_full;

  logic [32:0] ofifo [2];
  logic        o_wr, o_rd;
  logic [1:0]  o_count;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (!q_status.empty) state_next = ST_MUL;
      ST_MUL:   state_next = cur.tag.active ? ST_ADD : ST_END;
      ST_ADD:   state_next = ST_WAIT;
      ST_WAIT:  if (add_rsp.valid) state_next = ST_END;
      ST_END: begin
        if (!cur.tag.last) begin
          state_next = ST_IDLE;
        end else if (!cur.tag.err && cur.tag.tail_nonempty) begin
          state_next = ST_FINAL;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_FINAL: state_next = ST_FWAIT;
      ST_FWAIT: if (add_rsp.valid) state_next = ST_OUT;
      ST_OUT:   if (!out_full) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    add_req     = '0;
    out_push    = 1'b0;
    case (state)
      ST_IDLE: q_pop = !q_status.empty;
      ST_ADD: begin
        add_req.valid = 1'b1;
        add_req.a     = cur.tag.block ? block_sum : tail_sum;
        add_req.b     = prod;
        add_req.ftz   = cur.tag.block;
      end
      ST_FINAL: begin
        add_req.valid = 1'b1;
        add_req.a     = block_sum;
        add_req.b     = tail_sum;
        add_req.ftz   = 1'b0;
      end
      ST_OUT:  out_push = !out_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (state == ST_MUL) begin
      prod <= bf16_mul(cur.tag.elem, cur.query, cur.tag.block);
    end
    if (state == ST_END) begin
      res_err <= cur.tag.err;
      res_val <= cur.tag.err ? 32'd0 : canon(block_sum);
    end else if ((state == ST_FWAIT) && add_rsp.valid) begin
      res_val <= canon(add_rsp.sum);
    end
  end

  // Sums go back to +0 after each result and on a length write.
  always_ff @(posedge clk) begin
    if (rst || cfg_clear || out_push) begin
      block_sum <= '0;
      tail_sum  <= '0;
    end else if ((state == ST_WAIT) && add_rsp.valid) begin
      if (cur.tag.block) begin
        block_sum <= add_rsp.sum;
      end else begin
        tail_sum <= add_rsp.sum;
      end
    end
  end

  bfdp_fp_add u_add (
    .clk(clk),
    .rst(rst),
    .req(add_req),
    .rsp(add_rsp)
  );

  // Two-word result queue so the sequencer can go on while a result waits.
  assign out_full = (o_count == 2'd2);
  assign empty    = (o_count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr    <= 1'b0;
      o_rd    <= 1'b0;
      o_count <= '0;
    end else begin
      if (out_push) begin
        o_wr <= ~o_wr;
      end
      if (pop && !empty) begin
        o_rd <= ~o_rd;
      end
      o_count <= o_count + 2'(out_push) - 2'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      ofifo[o_wr] <= {res_err, res_val};
    end
  end

  assign dot_product = ofifo[o_rd][31:0];
  assign error       = ofifo[o_rd][32];

endmodule

// ===== hw/rtl/bf16_row_dot_product.sv =====
// bf16 row dot product with fp32 accumulation; top level.
// Load and row words both enter at one per cycle until the four-word element
// queue fills. The back end takes one queued element at a time: queue read,
// multiply, adder issue, adder wait and sum update for an active element,
// while an element of a zero-length row skips the add; each row end queues the
// result, after a final add when the row has a tail.
// Reset (synchronous, high) clears pointers, sums and queues, sets length 32.
module bf16_row_dot_product
  import bfdp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             cmd,
  input  logic [15:0]      element,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data,
  output logic             empty,
  input  logic             pop,
  output logic [31:0]      dot_product,
  output logic             error
);

  queue_status_t q_status;
  logic          q_push;
  logic          q_pop;
  entry_t        q_data;
  entry_t        q_head;
  logic          cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  bfdp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .cmd     (cmd),
    .element (element),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .q_status(q_status),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  bfdp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_data),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  bfdp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_clear  (cfg_we),
    .q_head     (q_head),
    .q_status   (q_status),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .dot_product(dot_product),
    .error      (error)
  );

  // An accepted row word reaches the element queue on the next cycle.
  a_row_to_queue: assert property (@(posedge clk) disable iff (rst)
    (push && !full && (cmd == CMD_ROW)) |=> q_push)
    else $error("accepted row word did not reach the element queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_status.count < QCNT_W'(QDEPTH)) || q_pop)
    else $error("element queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("element queue read while empty");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && error) |-> (dot_product == 32'd0))
    else $error("error word carries a nonzero result");

endmodule
